>>> hdl/binary_min_heap_queue_top_macros.svh
// assertion macros for the binary min-heap queue checker
// clocked on clk; the gated form is disabled while rst is high
`ifndef BINARY_MIN_HEAP_QUEUE_TOP_MACROS_SVH
`define BINARY_MIN_HEAP_QUEUE_TOP_MACROS_SVH

// property checked only outside reset
`define BMHQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every edge, reset included
`define BMHQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/bmhq_pkg.sv
// shared types, widths and codes for the binary min-heap queue
// no dependencies
package bmhq_pkg;

  localparam int DEPTH     = 512;
  localparam int KEY_W     = 24;
  localparam int TAG_W     = 9;
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int CH_W      = IDX_W + 2;
  localparam int CFG_W     = 10;
  localparam int COUNT_W   = 10;
  localparam int LIM_W     = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int CAP_RESET = 512;

  typedef enum logic [1:0] {
    REQ_APPEND  = 2'd0,
    REQ_BUILD   = 2'd1,
    REQ_INSERT  = 2'd2,
    REQ_EXTRACT = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_BLD_RD,
    S_BLD_LD,
    S_DN_RD,
    S_DN_CMP,
    S_EXT_RD,
    S_EXT_LD,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    RD_CHILD,
    RD_PARENT,
    RD_BIDX,
    RD_EXT
  } rd_sel_t;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_NEW,
    WR_V,
    WR_RDA,
    WR_CHILD
  } wr_sel_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } entry_t;

  typedef struct packed {
    logic    clear_res;
    logic    set_full;
    logic    set_empty;
    logic    grow;
    logic    bld_init;
    logic    bld_load;
    logic    bld_dec;
    logic    ext_load;
    logic    move_up;
    logic    move_down;
    rd_sel_t rd_sel;
    wr_sel_t wr_sel;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic size_lt2;
    logic pos_zero;
    logic up_stop;
    logic no_child;
    logic dn_stop;
    logic bidx_zero;
  } stat_t;

endpackage

>>> hdl/bmhq_datapath.sv
// heap datapath: entry memory, sift position and held entry, size and limit
// depends on bmhq_pkg; driven by the command struct from bmhq_ctrl
module bmhq_datapath
  import bmhq_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic [KEY_W-1:0]   in_key,
  input  logic [TAG_W-1:0]   in_tag,
  input  logic               cfg_we,
  input  logic [CFG_W-1:0]   cfg_wdata,
  input  cmd_t               cmd,
  output stat_t              stat,
  output logic [1:0]         res_status,
  output logic [KEY_W-1:0]   res_key,
  output logic [TAG_W-1:0]   res_tag,
  output logic [COUNT_W-1:0] res_count
);

  entry_t mem [DEPTH];
  entry_t rd_a;
  entry_t rd_b;
  entry_t v;

  logic [IDX_W-1:0] pos;
  logic [IDX_W-1:0] bidx;
  logic [CNT_W-1:0] size;
  logic [CFG_W-1:0] cap;
  status_t          status_q;
  logic [KEY_W-1:0] okey;
  logic [TAG_W-1:0] otag;

  logic [LIM_W-1:0] eff_limit;
  logic [CH_W-1:0]  l_full;
  logic [CH_W-1:0]  r_full;
  logic [IDX_W-1:0] l_idx;
  logic [IDX_W-1:0] r_idx;
  logic [IDX_W-1:0] parent;
  logic [IDX_W-1:0] last;
  logic             r_valid;
  logic             take_l;
  logic             take_r;
  logic [KEY_W-1:0] cand_key;
  entry_t           chosen;
  logic [IDX_W-1:0] chosen_idx;

  logic [IDX_W-1:0] rd_addr_a;
  logic [IDX_W-1:0] rd_addr_b;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;

  // capacity saturates at the memory depth
  assign eff_limit = (LIM_W'(cap) > LIM_W'(DEPTH)) ? LIM_W'(DEPTH) : LIM_W'(cap);

  assign l_full  = {1'b0, pos, 1'b1};
  assign r_full  = l_full + CH_W'(1);
  assign l_idx   = l_full[IDX_W-1:0];
  assign r_idx   = r_full[IDX_W-1:0];
  assign parent  = IDX_W'((pos - IDX_W'(1)) >> 1);
  assign last    = IDX_W'(size - CNT_W'(1));
  assign r_valid = r_full < CH_W'(size);

  // smaller child against the held entry, left wins a tie
  always_comb begin
    take_l     = rd_a.key < v.key;
    cand_key   = take_l ? rd_a.key : v.key;
    take_r     = r_valid && (rd_b.key < cand_key);
    chosen     = take_r ? rd_b : rd_a;
    chosen_idx = take_r ? r_idx : l_idx;
  end

  always_comb begin
    stat.full      = LIM_W'(size) >= eff_limit;
    stat.empty     = size == '0;
    stat.size_lt2  = size < CNT_W'(2);
    stat.pos_zero  = pos == '0;
    stat.up_stop   = rd_a.key <= v.key;
    stat.no_child  = l_full >= CH_W'(size);
    stat.dn_stop   = !take_l && !take_r;
    stat.bidx_zero = bidx == '0;
  end

  always_comb begin
    rd_addr_a = l_idx;
    rd_addr_b = r_idx;
    case (cmd.rd_sel)
      RD_PARENT: rd_addr_a = parent;
      RD_BIDX:   rd_addr_a = bidx;
      RD_EXT: begin
        rd_addr_a = '0;
        rd_addr_b = last;
      end
      default: begin
        rd_addr_a = l_idx;
        rd_addr_b = r_idx;
      end
    endcase
  end

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = pos;
    wr_data = v;
    case (cmd.wr_sel)
      WR_NEW: begin
        wr_addr = IDX_W'(size);
        wr_data = '{key: in_key, tag: in_tag};
      end
      WR_V:     wr_data = v;
      WR_RDA:   wr_data = rd_a;
      WR_CHILD: wr_data = chosen;
      default:  wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a <= mem[rd_addr_a];
    rd_b <= mem[rd_addr_b];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size <= '0;
      cap  <= CFG_W'(CAP_RESET);
    end else begin
      if (cfg_we) begin
        cap <= cfg_wdata;
      end
      if (cmd.grow) begin
        size <= size + CNT_W'(1);
      end else if (cmd.ext_load) begin
        size <= size - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.grow) begin
      v   <= '{key: in_key, tag: in_tag};
      pos <= IDX_W'(size);
    end else if (cmd.bld_load) begin
      v   <= rd_a;
      pos <= bidx;
    end else if (cmd.ext_load) begin
      v   <= rd_b;
      pos <= '0;
    end else if (cmd.move_up) begin
      pos <= parent;
    end else if (cmd.move_down) begin
      pos <= chosen_idx;
    end

    if (cmd.bld_init) begin
      bidx <= IDX_W'((size - CNT_W'(2)) >> 1);
    end else if (cmd.bld_dec) begin
      bidx <= bidx - IDX_W'(1);
    end

    if (cmd.set_full) begin
      status_q <= ST_FULL;
    end else if (cmd.set_empty) begin
      status_q <= ST_EMPTY;
    end else if (cmd.clear_res) begin
      status_q <= ST_OK;
    end
    if (cmd.clear_res) begin
      okey <= '0;
      otag <= '0;
    end
    if (cmd.ext_load) begin
      okey <= rd_a.key;
      otag <= rd_a.tag;
    end
  end

  assign res_status = status_q;
  assign res_key    = okey;
  assign res_tag    = otag;
  assign res_count  = COUNT_W'(size);

endmodule

>>> hdl/bmhq_ctrl.sv
// request sequencer for the heap: decodes requests and steps sift-up,
// sift-down and build; depends on bmhq_pkg, drives bmhq_datapath
module bmhq_ctrl
  import bmhq_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  req_t  req,
  input  stat_t stat,
  output cmd_t  cmd,
  output logic  busy,
  output logic  done,
  output logic  cfg_ready
);

  state_t state;
  state_t state_next;
  logic   building;
  logic   building_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      building <= 1'b0;
    end else begin
      state    <= state_next;
      building <= building_next;
    end
  end

  always_comb begin
    state_next    = state;
    building_next = building;
    cmd           = '0;
    cmd.rd_sel    = RD_CHILD;
    cmd.wr_sel    = WR_NONE;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.clear_res = 1'b1;
          building_next = req == REQ_BUILD;
          case (req)
            REQ_APPEND: begin
              state_next = S_DONE;
              if (stat.full) begin
                cmd.set_full = 1'b1;
              end else begin
                cmd.grow   = 1'b1;
                cmd.wr_sel = WR_NEW;
              end
            end
            REQ_INSERT: begin
              if (stat.full) begin
                cmd.set_full = 1'b1;
                state_next   = S_DONE;
              end else begin
                cmd.grow   = 1'b1;
                state_next = S_UP_RD;
              end
            end
            REQ_BUILD: begin
              if (stat.size_lt2) begin
                state_next = S_DONE;
              end else begin
                cmd.bld_init = 1'b1;
                state_next   = S_BLD_RD;
              end
            end
            REQ_EXTRACT: begin
              if (stat.empty) begin
                cmd.set_empty = 1'b1;
                state_next    = S_DONE;
              end else begin
                state_next = S_EXT_RD;
              end
            end
            default: state_next = S_DONE;
          endcase
        end
      end
      S_UP_RD: begin
        if (stat.pos_zero) begin
          cmd.wr_sel = WR_V;
          state_next = S_DONE;
        end else begin
          cmd.rd_sel = RD_PARENT;
          state_next = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        // parent data is registered; swap only on a strictly greater parent
        if (stat.up_stop) begin
          cmd.wr_sel = WR_V;
          state_next = S_DONE;
        end else begin
          cmd.wr_sel  = WR_RDA;
          cmd.move_up = 1'b1;
          state_next  = S_UP_RD;
        end
      end
      S_BLD_RD: begin
        cmd.rd_sel = RD_BIDX;
        state_next = S_BLD_LD;
      end
      S_BLD_LD: begin
        cmd.bld_load = 1'b1;
        state_next   = S_DN_RD;
      end
      S_EXT_RD: begin
        cmd.rd_sel = RD_EXT;
        state_next = S_EXT_LD;
      end
      S_EXT_LD: begin
        cmd.ext_load = 1'b1;
        state_next   = S_DN_RD;
      end
      S_DN_RD: begin
        if (stat.no_child) begin
          cmd.wr_sel = WR_V;
          if (building && !stat.bidx_zero) begin
            cmd.bld_dec = 1'b1;
            state_next  = S_BLD_RD;
          end else begin
            state_next = S_DONE;
          end
        end else begin
          cmd.rd_sel = RD_CHILD;
          state_next = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        if (stat.dn_stop) begin
          cmd.wr_sel = WR_V;
          // next build node, or finish
          if (building && !stat.bidx_zero) begin
            cmd.bld_dec = 1'b1;
            state_next  = S_BLD_RD;
          end else begin
            state_next = S_DONE;
          end
        end else begin
          cmd.wr_sel    = WR_CHILD;
          cmd.move_down = 1'b1;
          state_next    = S_DN_RD;
        end
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy      = state != S_IDLE;
  assign done      = state == S_DONE;
  assign cfg_ready = state == S_IDLE;

endmodule

>>> hdl/binary_min_heap_queue_top.sv
// append, dropped request, empty extract and small build strobe done in the cycle after
// start; insert climbs one level per parent read and compare until it stops or reaches the root;
// extract reads root and last entry and sifts down, build loads and sifts down each node
// from the last parent back to the root; the entry memory has a registered-read port pair
// one request at a time, next start taken the cycle after done; results cannot be stalled
// sync rst empties the heap and sets the capacity to 512; memory contents are not cleared
module binary_min_heap_queue_top
  import bmhq_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         req_type,
  input  logic [KEY_W-1:0]   entry_key,
  input  logic [TAG_W-1:0]   entry_tag,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CFG_W-1:0]   cfg_data,
  output logic               done,
  output logic [1:0]         status,
  output logic [KEY_W-1:0]   out_key,
  output logic [TAG_W-1:0]   out_tag,
  output logic [COUNT_W-1:0] count
);

  cmd_t  cmd;
  stat_t stat;
  logic  cfg_we;

  assign cfg_we = cfg_valid && cfg_ready;

  bmhq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .req       (req_t'(req_type)),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .done      (done),
    .cfg_ready (cfg_ready)
  );

  bmhq_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .in_key     (entry_key),
    .in_tag     (entry_tag),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_data),
    .cmd        (cmd),
    .stat       (stat),
    .res_status (status),
    .res_key    (out_key),
    .res_tag    (out_tag),
    .res_count  (count)
  );

endmodule

>>> hdl/bmhq_checker.sv
// port-level checks for the heap queue top, attached by bind
// depends on bmhq_pkg and binary_min_heap_queue_top_macros.svh
`include "binary_min_heap_queue_top_macros.svh"

module bmhq_checker
  import bmhq_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input logic [1:0]         status,
  input logic [KEY_W-1:0]   out_key,
  input logic [TAG_W-1:0]   out_tag,
  input logic [COUNT_W-1:0] count
);

  // an accepted request makes the block busy
  `BMHQ_ASSERT(a_accept_busy, start && !busy |=> busy, "request accepted but not busy")
  // result strobe lasts one cycle and the block is free right after
  `BMHQ_ASSERT(a_done_pulse, done |=> !done && !busy, "done not a single pulse")
  // empty extract reports nothing held and zero payload
  `BMHQ_ASSERT(a_empty_zero,
    done && status == ST_EMPTY |-> count == '0 && out_key == '0 && out_tag == '0,
    "empty status with nonzero payload")
  `BMHQ_ASSERT_ALWAYS(a_reset_idle, rst |=> !busy && !done, "not idle after reset")

endmodule

bind binary_min_heap_queue_top bmhq_checker u_checker (.*);

>>> verif/tb_binary_min_heap_queue_top.sv
`timescale 1ns / 100ps
// testbench for binary_min_heap_queue_top: directed and random requests checked
// against a heap predictor held in a scoreboard class; depends on bmhq_pkg and the top module

import bmhq_pkg::*;

typedef struct {
  status_t            st;
  logic [KEY_W-1:0]   key;
  logic [TAG_W-1:0]   tag;
  logic [COUNT_W-1:0] cnt;
} heap_result_t;

class heap_scoreboard;
  logic [KEY_W-1:0] keys [DEPTH];
  logic [TAG_W-1:0] tags [DEPTH];
  int unsigned      size;
  int unsigned      peak;
  int unsigned      capacity;
  heap_result_t     pending_results[$];
  int unsigned      mismatches;
  int unsigned      compared;
  int unsigned      n_full;
  int unsigned      n_empty;
  int unsigned      req_seen [4];

  function new();
    size = 0;
    peak = 0;
    capacity = CAP_RESET;
    mismatches = 0;
    compared = 0;
    n_full = 0;
    n_empty = 0;
    foreach (req_seen[i]) req_seen[i] = 0;
  endfunction

  function void set_capacity(logic [CFG_W-1:0] v);
    capacity = v;
  endfunction

  function void swap_entries(int unsigned a, int unsigned b);
    logic [KEY_W-1:0] k;
    logic [TAG_W-1:0] t;
    k = keys[a];
    t = tags[a];
    keys[a] = keys[b];
    tags[a] = tags[b];
    keys[b] = k;
    tags[b] = t;
  endfunction

  // left child wins a tie since the right one must be strictly smaller
  function void sift_down(int unsigned pos);
    int unsigned l;
    int unsigned r;
    int unsigned m;
    while (pos < size) begin
      l = 2 * pos + 1;
      r = l + 1;
      m = pos;
      if (l < size && keys[l] < keys[pos]) m = l;
      if (r < size && keys[r] < keys[m]) m = r;
      if (m == pos) break;
      swap_entries(m, pos);
      pos = m;
    end
  endfunction

  function void sift_up(int unsigned pos);
    int unsigned p;
    while (pos > 0) begin
      p = (pos - 1) / 2;
      if (keys[p] <= keys[pos]) break;
      swap_entries(p, pos);
      pos = p;
    end
  endfunction

  function void note_request(req_t r, logic [KEY_W-1:0] k, logic [TAG_W-1:0] t);
    heap_result_t res;
    int unsigned  lim;
    int           i;
    res.st = ST_OK;
    res.key = '0;
    res.tag = '0;
    lim = (capacity > DEPTH) ? DEPTH : capacity;
    req_seen[r]++;
    case (r)
      REQ_APPEND, REQ_INSERT: begin
        if (size >= lim) begin
          res.st = ST_FULL;
        end else begin
          keys[size] = k;
          tags[size] = t;
          size++;
          if (r == REQ_INSERT) sift_up(size - 1);
        end
      end
      REQ_BUILD: begin
        if (size >= 2) begin
          for (i = (size - 2) / 2; i >= 0; i--) sift_down(i);
        end
      end
      default: begin
        if (size == 0) begin
          res.st = ST_EMPTY;
        end else begin
          res.key = keys[0];
          res.tag = tags[0];
          keys[0] = keys[size - 1];
          tags[0] = tags[size - 1];
          size--;
          sift_down(0);
        end
      end
    endcase
    res.cnt = COUNT_W'(size);
    if (res.st == ST_FULL) n_full++;
    if (res.st == ST_EMPTY) n_empty++;
    if (size > peak) peak = size;
    pending_results.push_back(res);
  endfunction

  task report_mismatch(string msg);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task check_result(logic [1:0] st, logic [KEY_W-1:0] key, logic [TAG_W-1:0] tag,
                    logic [COUNT_W-1:0] cnt);
    heap_result_t e;
    compared++;
    if (pending_results.size() == 0) begin
      report_mismatch($sformatf("result #%0d with no request pending (status %0d key %0h)",
                                compared, st, key));
      return;
    end
    e = pending_results.pop_front();
    if (st !== e.st)
      report_mismatch($sformatf("result #%0d status %0d, want %0d", compared, st, e.st));
    if (key !== e.key)
      report_mismatch($sformatf("result #%0d out_key %0h, want %0h", compared, key, e.key));
    if (tag !== e.tag)
      report_mismatch($sformatf("result #%0d out_tag %0h, want %0h", compared, tag, e.tag));
    if (cnt !== e.cnt)
      report_mismatch($sformatf("result #%0d count %0d, want %0d", compared, cnt, e.cnt));
  endtask

  task report_leftovers();
    heap_result_t e;
    while (pending_results.size() != 0) begin
      e = pending_results.pop_front();
      report_mismatch($sformatf("no result for a request (status %0d count %0d)",
                                e.st, e.cnt));
    end
  endtask
endclass

module tb_binary_min_heap_queue_top;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         req_type = REQ_APPEND;
  logic [KEY_W-1:0]   entry_key = '0;
  logic [TAG_W-1:0]   entry_tag = '0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CFG_W-1:0]   cfg_data = '0;
  logic               done;
  logic [1:0]         status;
  logic [KEY_W-1:0]   out_key;
  logic [TAG_W-1:0]   out_tag;
  logic [COUNT_W-1:0] count;

  heap_scoreboard sb;

  binary_min_heap_queue_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req_type  (req_type),
    .entry_key (entry_key),
    .entry_tag (entry_tag),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .done      (done),
    .status    (status),
    .out_key   (out_key),
    .out_tag   (out_tag),
    .count     (count)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.set_capacity(cfg_data);
      if (start && !busy) sb.note_request(req_t'(req_type), entry_key, entry_tag);
      if (done) sb.check_result(status, out_key, out_tag, count);
    end
  end

  initial begin
    #10ms;
    $display("binary_min_heap_queue_top verification failed");
    $finish;
  end

  function automatic logic [KEY_W-1:0] rand_key();
    case ($urandom_range(5))
      0: return '0;
      1: return {KEY_W{1'b1}};
      2: return KEY_W'($urandom_range(15));
      3: return KEY_W'($urandom_range(255));
      default: return KEY_W'($urandom);
    endcase
  endfunction

  function automatic logic [TAG_W-1:0] rand_tag();
    return TAG_W'($urandom_range(511));
  endfunction

  // issue one request, idling the sender first at the given rate
  task automatic issue(req_t r, logic [KEY_W-1:0] k, logic [TAG_W-1:0] t, int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start = 1'b1;
    req_type = r;
    entry_key = k;
    entry_tag = t;
    do @(posedge clk); while (busy);
    @(negedge clk);
    start = 1'b0;
  endtask

  task automatic wait_drain();
    while (sb.pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_capacity(logic [CFG_W-1:0] v);
    wait_drain();
    cfg_valid = 1'b1;
    cfg_data = v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic req_t pick_req(int target);
    int r;
    int add_pct;
    r = $urandom_range(99);
    add_pct = (sb.size < target) ? 65 : 30;
    if (r < 5) return REQ_BUILD;
    if (r < 5 + add_pct) return ($urandom_range(9) < 6) ? REQ_INSERT : REQ_APPEND;
    return REQ_EXTRACT;
  endfunction

  // mostly single requests around a target size, now and then a raw burst
  // that is heapified and partly drained
  task automatic run_phase(int n_items, int target, int idle_pct, int pause_pct);
    int sent;
    int n;
    int j;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < pause_pct) wait_drain();
      if ($urandom_range(99) < 6) begin
        n = $urandom_range(1, 10);
        for (j = 0; j < n; j++) issue(REQ_APPEND, rand_key(), rand_tag(), idle_pct);
        issue(REQ_BUILD, rand_key(), rand_tag(), idle_pct);
        for (j = 0; j < n; j++) issue(REQ_EXTRACT, rand_key(), rand_tag(), idle_pct);
        sent += 2 * n + 1;
      end else begin
        issue(pick_req(target), rand_key(), rand_tag(), idle_pct);
        sent++;
      end
    end
  endtask

  initial begin
    int j;
    sb = new();
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // empty heap, small builds, ties on insert, raw appends fixed by build
    issue(REQ_EXTRACT, '0, '0, 0);
    issue(REQ_BUILD, '0, '0, 0);
    issue(REQ_APPEND, {KEY_W{1'b1}}, {TAG_W{1'b1}}, 0);
    issue(REQ_BUILD, '0, '0, 0);
    issue(REQ_INSERT, '0, '0, 0);
    issue(REQ_INSERT, 24'd5, 9'h0AA, 0);
    issue(REQ_INSERT, 24'd5, 9'h155, 0);
    issue(REQ_APPEND, 24'd3, 9'h001, 0);
    issue(REQ_APPEND, 24'd5, 9'h002, 0);
    issue(REQ_BUILD, '0, '0, 0);
    for (j = 0; j < 6; j++) issue(REQ_EXTRACT, '0, '0, 0);

    // capacity zero drops everything that adds
    write_capacity(10'd0);
    issue(REQ_APPEND, 24'h123456, 9'h0F0, 0);
    issue(REQ_INSERT, 24'h654321, 9'h10F, 0);
    issue(REQ_EXTRACT, '0, '0, 0);

    write_capacity(10'd2);
    issue(REQ_INSERT, 24'd7, 9'h011, 0);
    issue(REQ_INSERT, 24'd7, 9'h022, 0);
    issue(REQ_APPEND, 24'd1, 9'h033, 0);

    // capacity written below the current size
    write_capacity(10'd1);
    issue(REQ_APPEND, 24'd2, 9'h044, 0);
    issue(REQ_EXTRACT, '0, '0, 0);
    issue(REQ_INSERT, 24'd3, 9'h055, 0);
    issue(REQ_EXTRACT, '0, '0, 0);
    issue(REQ_INSERT, 24'd4, 9'h066, 0);

    write_capacity(10'd512);
    run_phase(220, 20, 0, 0);
    write_capacity(10'd7);
    run_phase(200, 6, 72, 0);
    write_capacity(10'd1);
    run_phase(100, 2, 0, 0);
    write_capacity(10'd300);
    run_phase(250, 40, 19, 2);
    write_capacity(10'd1023);
    run_phase(150, 60, 72, 0);

    // fill to the depth, overflow, then heapify and drain part of it
    while (sb.size < DEPTH)
      issue(($urandom_range(3) == 0) ? REQ_INSERT : REQ_APPEND, rand_key(), rand_tag(), 19);
    issue(REQ_APPEND, rand_key(), rand_tag(), 19);
    issue(REQ_INSERT, rand_key(), rand_tag(), 19);
    issue(REQ_BUILD, '0, '0, 19);
    for (j = 0; j < 25; j++) issue(REQ_EXTRACT, rand_key(), rand_tag(), 19);
    for (j = 0; j < 4; j++) issue(REQ_INSERT, rand_key(), rand_tag(), 19);
    issue(REQ_BUILD, '0, '0, 19);
    for (j = 0; j < 4; j++) issue(REQ_EXTRACT, rand_key(), rand_tag(), 0);

    wait_drain();
    repeat (30) @(negedge clk);
    sb.report_leftovers();

    $display("requests: %0d append, %0d build, %0d insert, %0d extract; %0d full, %0d empty",
             sb.req_seen[REQ_APPEND], sb.req_seen[REQ_BUILD], sb.req_seen[REQ_INSERT],
             sb.req_seen[REQ_EXTRACT], sb.n_full, sb.n_empty);
    $display("%0d results compared, largest heap %0d entries, %0d mismatches",
             sb.compared, sb.peak, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("binary_min_heap_queue_top verification clean");
    end else begin
      $display("binary_min_heap_queue_top verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hdl
hdl/bmhq_pkg.sv
hdl/bmhq_datapath.sv
hdl/bmhq_ctrl.sv
hdl/binary_min_heap_queue_top.sv
hdl/bmhq_checker.sv
verif/tb_binary_min_heap_queue_top.sv
